[hdl/free_slot_stack_allocator_defines.svh]
// Assertion helpers shared by the allocator modules.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef FREE_SLOT_STACK_ALLOCATOR_DEFINES_SVH
`define FREE_SLOT_STACK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, off during reset
`define FSA_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, off during reset
`define FSA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hdl/fsa_pkg.sv]
`timescale 1ns / 1ps
package fsa_pkg;

    // Default pool depth
    localparam int unsigned POOL_SIZE_DEF = 64;

    // Beat field widths
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned SLOT_W   = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_INACTIVE = 2'd2
    } t_status;

    // Shift commands broadcast to every stack cell
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_stack_ctl;

endpackage

[hdl/fsa_if.sv]
`timescale 1ns / 1ps
// Request channel: one beat per allocator command
interface fsa_in_if import fsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, output action, output slot, input ready);
    modport sink   (input valid, input action, input slot, output ready);
endinterface

// Response channel: one beat per command
interface fsa_out_if import fsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   granted_slot;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;

    modport source (output valid, output granted_slot, output status, output free_count,
                    input ready);
    modport sink   (input valid, input granted_slot, input status, input free_count,
                    output ready);
endinterface

[hdl/fsa_cell.sv]
`timescale 1ns / 1ps
module fsa_cell import fsa_pkg::*; #(
    parameter int unsigned EW   = 6,
    parameter int unsigned INIT = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_stack_ctl    i_ctl,
    input  logic [EW-1:0] i_from_above,
    input  logic [EW-1:0] i_from_below,
    output logic [EW-1:0] o_data
);

    localparam logic [EW-1:0] INIT_VAL = EW'(INIT);

    logic [EW-1:0] r_data;
    logic [EW-1:0] n_data;

    // Reload on clear, shift down on push, shift up on pop
    always_comb begin
        n_data = r_data;
        if (i_ctl.clear) begin
            n_data = INIT_VAL;
        end else if (i_ctl.push) begin
            n_data = i_from_above;
        end else if (i_ctl.pop) begin
            n_data = i_from_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= INIT_VAL;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

[hdl/fsa_stack.sv]
`timescale 1ns / 1ps
`include "free_slot_stack_allocator_defines.svh"
module fsa_stack import fsa_pkg::*; #(
    parameter int unsigned POOL_SIZE = POOL_SIZE_DEF,
    localparam int unsigned EW = $clog2(POOL_SIZE),
    localparam int unsigned CW = $clog2(POOL_SIZE + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_stack_ctl    i_ctl,
    input  logic [EW-1:0] i_push_data,
    output logic [EW-1:0] o_top_data,
    output logic [CW-1:0] o_count
);

    localparam logic [CW-1:0] FULL = CW'(POOL_SIZE);

    logic [EW-1:0] w_cell [POOL_SIZE];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // Cell 0 is the top of stack; deeper cells hold older free slots
    for (genvar k = 0; k < POOL_SIZE; k++) begin : g_cell
        logic [EW-1:0] w_above;
        logic [EW-1:0] w_below;

        if (k == 0) begin : g_head
            assign w_above = i_push_data;
        end else begin : g_body
            assign w_above = w_cell[k-1];
        end

        if (k == POOL_SIZE - 1) begin : g_tail
            assign w_below = w_cell[k];
        end else begin : g_mid
            assign w_below = w_cell[k+1];
        end

        fsa_cell #(
            .EW   (EW),
            .INIT (POOL_SIZE - 1 - k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_data       (w_cell[k])
        );
    end

    // Track the number of free entries
    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = FULL;
        end else if (i_ctl.push && r_count != FULL) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop && r_count != '0) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= FULL;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_top_data = w_cell[0];
    assign o_count    = r_count;

    `FSA_ASSERT_IMPL(a_no_push_full, i_ctl.push, int'(r_count) < POOL_SIZE)
    `FSA_ASSERT_IMPL(a_no_pop_empty, i_ctl.pop, r_count != '0)
    `FSA_ASSERT_NEXT(a_clear_fills, i_ctl.clear, int'(r_count) == POOL_SIZE)

endmodule

[hdl/free_slot_stack_allocator.sv]
`timescale 1ns / 1ps
// A command beat's response beat is registered and appears in the cycle after acceptance.
// Throughput: one command per cycle while the response side keeps up; clear
// also goes at that rate, since every stack cell reloads its slot number at once.
// Input ready drops only while a response beat waits in the output register.
// Reset (synchronous, active low): stack cells hold 0..POOL_SIZE-1 with the
// highest on top, free count is POOL_SIZE, all active bits clear.
`include "free_slot_stack_allocator_defines.svh"
module free_slot_stack_allocator import fsa_pkg::*; #(
    parameter int unsigned POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fsa_in_if.sink    i_in,
    fsa_out_if.source o_out
);

    localparam int unsigned EW = $clog2(POOL_SIZE);
    localparam int unsigned CW = $clog2(POOL_SIZE + 1);
    localparam int unsigned SW = (EW > SLOT_W) ? EW : SLOT_W;

    t_stack_ctl          n_ctl;
    logic [EW-1:0]       w_top_slot;
    logic [CW-1:0]       w_count;
    logic [CW+COUNT_W-1:0] w_count_ext;
    logic [EW+SLOT_W-1:0]  w_top_ext;
    logic [SW-1:0]       w_slot_ext;
    logic [EW-1:0]       w_slot_idx;
    logic                w_slot_active;
    logic                w_in_fire;
    logic                w_grant_ok;
    logic                w_free_ok;

    logic [POOL_SIZE-1:0] r_active;
    logic [POOL_SIZE-1:0] n_active;
    logic                 r_out_valid;
    logic [SLOT_W-1:0]    r_granted;
    logic [SLOT_W-1:0]    n_granted;
    t_status              r_status;
    t_status              n_status;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;

    // Look up the active bit of the slot named by a free
    assign w_slot_ext    = SW'(i_in.slot);
    assign w_slot_idx    = w_slot_ext[EW-1:0];
    assign w_slot_active = (int'(w_slot_ext) < POOL_SIZE) && r_active[w_slot_idx];

    // Decode the command into stack moves and a status
    always_comb begin
        n_ctl      = '0;
        n_status   = ST_OK;
        w_grant_ok = 1'b0;
        w_free_ok  = 1'b0;
        if (w_in_fire) begin
            unique case (i_in.action)
                ACT_ALLOC: begin
                    if (w_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_ctl.pop  = 1'b1;
                        w_grant_ok = 1'b1;
                    end
                end
                ACT_FREE: begin
                    if (!w_slot_active) begin
                        n_status = ST_INACTIVE;
                    end else begin
                        w_free_ok  = 1'b1;
                        n_ctl.push = int'(w_count) < POOL_SIZE;
                    end
                end
                ACT_CLEAR: begin
                    n_ctl.clear = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Update active bits
    always_comb begin
        n_active = r_active;
        if (n_ctl.clear) begin
            n_active = '0;
        end else if (w_grant_ok) begin
            n_active[w_top_slot] = 1'b1;
        end else if (w_free_ok) begin
            n_active[w_slot_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else begin
            r_active <= n_active;
        end
    end

    fsa_stack #(
        .POOL_SIZE (POOL_SIZE)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (n_ctl),
        .i_push_data (w_slot_idx),
        .o_top_data  (w_top_slot),
        .o_count     (w_count)
    );

    // Hold the response beat until taken
    assign w_top_ext = {{SLOT_W{1'b0}}, w_top_slot};
    assign n_granted = w_grant_ok ? w_top_ext[SLOT_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_granted <= n_granted;
            r_status  <= n_status;
        end
    end

    // Stack count changes only with an accepted beat, so it tracks the held response
    assign w_count_ext        = {{COUNT_W{1'b0}}, w_count};
    assign o_out.valid        = r_out_valid;
    assign o_out.granted_slot = r_granted;
    assign o_out.status       = r_status;
    assign o_out.free_count   = w_count_ext[COUNT_W-1:0];

    `FSA_ASSERT_IMPL(a_count_matches_active, 1'b1, int'(w_count) + $countones(r_active) == POOL_SIZE)
    `FSA_ASSERT_NEXT(a_alloc_pops, w_grant_ok, w_count == $past(w_count) - 1'b1)
    `FSA_ASSERT_NEXT(a_clear_resets, n_ctl.clear, (int'(w_count) == POOL_SIZE) && (r_active == '0))
    `FSA_ASSERT_NEXT(a_fail_no_change, w_in_fire && n_status != ST_OK, $stable(r_active) && $stable(w_count))

endmodule

[tb/free_slot_stack_allocator_tb.sv]
`timescale 1ns / 1ps
module free_slot_stack_allocator_tb;
    import fsa_pkg::*;

    localparam int unsigned POOL         = POOL_SIZE_DEF;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int unsigned IDLE_PCT     = 14;
    localparam int unsigned RUN_LIMIT_NS = 10_000_000;

    typedef struct packed {
        logic [SLOT_W-1:0]  granted_slot;
        t_status            status;
        logic [COUNT_W-1:0] free_count;
    } t_alloc_rsp;

    logic i_clk;
    logic i_rst_n;

    fsa_in_if  cmd_if ();
    fsa_out_if rsp_if ();

    free_slot_stack_allocator #(.POOL_SIZE(POOL)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (rsp_if)
    );

    // Mirror of the allocator state
    logic [SLOT_W-1:0] pool_stack [POOL];
    int unsigned       pool_top;
    logic              slot_in_use [POOL];

    t_alloc_rsp  expected_rsp [$];
    int unsigned error_count = 0;
    bit          steady_flow = 1'b0;
    int unsigned n_cmds = 0;
    int unsigned n_granted = 0;
    int unsigned n_empty = 0;
    int unsigned n_inactive = 0;
    int unsigned n_clear = 0;
    int unsigned n_unused = 0;

    // Clock: 20 ns period
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Hard stop for a hung handshake
    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t ns: run limit reached, %0d responses still outstanding",
                 $time, expected_rsp.size());
        $display("== FAIL ==");
        $finish;
    end

    // Put every slot back on the stack, lowest at the bottom
    function automatic void refill_pool_mirror();
        for (int i = 0; i < POOL; i++) begin
            pool_stack[i]  = SLOT_W'(i);
            slot_in_use[i] = 1'b0;
        end
        pool_top = POOL;
    endfunction

    // Advance the mirror by one command and return the response it must produce
    function automatic t_alloc_rsp predict_alloc_response(input logic [ACTION_W-1:0] act,
                                                          input logic [SLOT_W-1:0]   slot);
        t_alloc_rsp rsp;
        rsp.granted_slot = '0;
        rsp.status       = ST_OK;
        n_cmds++;
        case (act)
            ACT_ALLOC: begin
                if (pool_top == 0) begin
                    rsp.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    pool_top--;
                    rsp.granted_slot = pool_stack[pool_top];
                    slot_in_use[rsp.granted_slot] = 1'b1;
                    n_granted++;
                end
            end
            ACT_FREE: begin
                if (!slot_in_use[slot]) begin
                    rsp.status = ST_INACTIVE;
                    n_inactive++;
                end else begin
                    slot_in_use[slot] = 1'b0;
                    // an active slot is never on the stack, so this always fits
                    if (pool_top < POOL) begin
                        pool_stack[pool_top] = slot;
                        pool_top++;
                    end
                end
            end
            ACT_CLEAR: begin
                refill_pool_mirror();
                n_clear++;
            end
            default: begin
                n_unused++;
            end
        endcase
        rsp.free_count = COUNT_W'(pool_top);
        return rsp;
    endfunction

    // Pick a random slot that is currently handed out, or -1 if none is
    function automatic int pick_busy_slot();
        int busy [$];
        for (int i = 0; i < POOL; i++) begin
            if (slot_in_use[i]) busy.push_back(i);
        end
        if (busy.size() == 0) return -1;
        return busy[$urandom_range(busy.size() - 1)];
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // Send one command beat; entered and left at a falling edge
    task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] slot);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.action <= act;
        cmd_if.slot   <= slot;
        do @(posedge i_clk); while (!cmd_if.ready);
        expected_rsp.push_back(predict_alloc_response(act, slot));
        @(negedge i_clk);
    endtask

    // Hold off commands until every response has come back
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_rsp.size() != 0) @(negedge i_clk);
    endtask

    // Response side: stall at random unless the flow is held steady
    always @(negedge i_clk) begin
        rsp_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each response beat with the oldest prediction
    always @(posedge i_clk) begin
        t_alloc_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t ns: unexpected response beat: slot %0d status %0d count %0d",
                         $time, rsp_if.granted_slot, rsp_if.status, rsp_if.free_count);
                error_count++;
            end else begin
                want = expected_rsp.pop_front();
                check_field("granted_slot", 8'(want.granted_slot), 8'(rsp_if.granted_slot));
                check_field("status", 8'(want.status), 8'(rsp_if.status));
                check_field("free_count", 8'(want.free_count), 8'(rsp_if.free_count));
            end
        end
    end

    // LIFO order after reset, bad frees, unused code and clear over a mixed pool
    task automatic test_directed();
        send_cmd(ACT_ALLOC, 6'd63);
        send_cmd(ACT_ALLOC, 6'd0);
        send_cmd(ACT_ALLOC, 6'd17);
        send_cmd(ACT_FREE, 6'd62);
        send_cmd(ACT_FREE, 6'd62);
        send_cmd(ACT_FREE, 6'd0);
        send_cmd(ACT_FREE, 6'd63);
        send_cmd(ACT_ALLOC, 6'd0);
        send_cmd(ACT_UNUSED, 6'd63);
        send_cmd(ACT_UNUSED, 6'd0);
        send_cmd(ACT_CLEAR, 6'd42);
        send_cmd(ACT_FREE, 6'd61);
        send_cmd(ACT_ALLOC, 6'd21);
        send_cmd(ACT_CLEAR, 6'd63);
        send_cmd(ACT_CLEAR, 6'd0);
        send_cmd(ACT_ALLOC, 6'd0);
        send_cmd(ACT_FREE, 6'd63);
        send_cmd(ACT_FREE, 6'd63);
    endtask

    // Random traffic: mostly legal alloc/free pairs, with a little noise
    task automatic test_random_round(input int unsigned n_items, input int unsigned p_alloc,
                                     input int unsigned p_clear);
        int unsigned r;
        int          busy;
        for (int unsigned k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            busy = pick_busy_slot();
            if (r < p_alloc) begin
                send_cmd(ACT_ALLOC, SLOT_W'($urandom_range(63)));
            end else if (r < p_clear + p_alloc) begin
                send_cmd(ACT_CLEAR, SLOT_W'($urandom_range(63)));
            end else if (r == 99) begin
                send_cmd(ACT_UNUSED, SLOT_W'($urandom_range(63)));
            end else if (r >= 95 || busy < 0) begin
                send_cmd(ACT_FREE, SLOT_W'($urandom_range(63)));
            end else begin
                send_cmd(ACT_FREE, SLOT_W'(busy));
            end
        end
    endtask

    // Drive the pool to empty and keep allocating against it
    task automatic test_exhaust_pool();
        test_random_round(250, 80, 0);
    endtask

    // Return most slots, then pull and push with both sides never stalling
    task automatic test_release_and_steady();
        test_random_round(150, 25, 1);
        steady_flow = 1'b1;
        test_random_round(150, 50, 1);
        cmd_if.valid <= 1'b0;
        @(negedge i_clk);
        steady_flow = 1'b0;
    endtask

    // Exhaust again from a scrambled stack, then mixed traffic with clears
    task automatic test_mixed_traffic();
        test_random_round(200, 80, 0);
        test_random_round(150, 50, 2);
    endtask

    initial begin
        cmd_if.valid  = 1'b0;
        cmd_if.action = ACT_ALLOC;
        cmd_if.slot   = '0;
        rsp_if.ready  = 1'b0;
        i_rst_n       = 1'b0;
        refill_pool_mirror();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_exhaust_pool();
        wait_drained();
        test_release_and_steady();
        test_mixed_traffic();

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Ran %0d commands: %0d grants, %0d allocations from an empty pool,",
                 n_cmds, n_granted, n_empty);
        $display("%0d frees of inactive slots, %0d clears, %0d unused action codes.",
                 n_inactive, n_clear, n_unused);
        if (error_count == 0 && expected_rsp.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
